// ----- hw/rtl/lcdw_pkg.sv -----
`default_nettype none

package lcdw_pkg;

    localparam int COL_W     = 6;
    localparam int ROW_W     = 2;
    localparam int LINE_W    = 3;
    localparam int RUN_SLOTS = 4;
    localparam int SLOT_W    = $clog2(RUN_SLOTS);

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_MOVE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic REG_COLUMN_COUNT = 1'b0;
    localparam logic REG_LINE_COUNT   = 1'b1;

    localparam logic [7:0] NEWLINE_CODE = 8'h0a;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;
    localparam logic [7:0] ROW1_OFFSET  = 8'h40;

    localparam logic [COL_W-1:0]  COLS_MAX    = 6'd40;
    localparam logic [LINE_W-1:0] LINES_MAX   = 3'd4;
    localparam logic [COL_W-1:0]  COLS_RESET  = 6'd16;
    localparam logic [LINE_W-1:0] LINES_RESET = 3'd2;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0]  column_count;
        logic [LINE_W-1:0] line_count;
    } t_cfg;

    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
    } t_nibble;

    typedef struct packed {
        t_nibble [RUN_SLOTS-1:0] slot;
        logic [SLOT_W-1:0]       last;
    } t_run;

    typedef struct packed {
        logic load;
        t_run run;
    } t_run_load;

endpackage

`default_nettype wire

// ----- hw/rtl/lcdw_in_if.sv -----
`default_nettype none

interface lcdw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [5:0] target_column;
    logic [1:0] target_row;

    modport source (output valid, opcode, char_code, target_column, target_row, input ready);
    modport sink   (input valid, opcode, char_code, target_column, target_row, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lcdw_out_if.sv -----
`default_nettype none

interface lcdw_out_if;
    logic       valid;
    logic       ready;
    logic       register_select;
    logic [3:0] bus_nibble;
    logic       last_of_run;

    modport source (output valid, register_select, bus_nibble, last_of_run, input ready);
    modport sink   (input valid, register_select, bus_nibble, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lcdw_cfg.sv -----
`default_nettype none

module lcdw_cfg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_index,
    input  wire logic [lcdw_pkg::COL_W-1:0] i_cfg_data,
    output lcdw_pkg::t_cfg                 o_cfg
);
    import lcdw_pkg::*;

    logic [COL_W-1:0]  r_column_count, n_column_count;
    logic [LINE_W-1:0] r_line_count, n_line_count;

    always_comb begin
        n_column_count = r_column_count;
        n_line_count   = r_line_count;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COLUMN_COUNT: begin
                    n_column_count = (i_cfg_data > COLS_MAX) ? COLS_MAX : i_cfg_data;
                end
                REG_LINE_COUNT: begin
                    n_line_count = (i_cfg_data[LINE_W-1:0] > LINES_MAX) ? LINES_MAX
                                                                       : i_cfg_data[LINE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= COLS_RESET;
            r_line_count   <= LINES_RESET;
        end else begin
            r_column_count <= n_column_count;
            r_line_count   <= n_line_count;
        end
    end

    assign o_cfg.column_count = r_column_count;
    assign o_cfg.line_count   = r_line_count;

endmodule

`default_nettype wire

// ----- hw/rtl/lcdw_step.sv -----
`default_nettype none

module lcdw_step (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [1:0]                i_opcode,
    input  wire logic [7:0]                i_char_code,
    input  wire logic [lcdw_pkg::COL_W-1:0] i_target_column,
    input  wire logic [lcdw_pkg::ROW_W-1:0] i_target_row,
    input  wire lcdw_pkg::t_cfg            i_cfg,
    output lcdw_pkg::t_run_load            o_run
);
    import lcdw_pkg::*;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_wrapped, n_wrapped;

    logic             is_nl;
    logic             skip;
    logic [COL_W:0]   col_pre;
    logic             wrap;
    logic [LINE_W-1:0] row_pre;
    logic [COL_W-1:0] put_col;
    logic [ROW_W-1:0] put_row;
    logic [7:0]       put_cmd;
    logic [7:0]       move_cmd;

    function automatic logic [7:0] ddram_cmd(input logic [COL_W-1:0] col,
                                             input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] cols);
        logic [7:0] addr;
        addr = {2'b00, col};
        if (row[0]) addr = addr + ROW1_OFFSET;
        if (row[1]) addr = addr + {2'b00, cols};
        return CMD_DDRAM | addr;
    endfunction

    function automatic t_nibble nib_of(input logic rs, input logic [3:0] nib);
        t_nibble w;
        w.rs  = rs;
        w.nib = nib;
        return w;
    endfunction

    always_comb begin
        is_nl   = (i_char_code == NEWLINE_CODE);
        skip    = is_nl && !r_wrapped;
        col_pre = skip ? {1'b0, i_cfg.column_count} : ({1'b0, r_col} + 7'd1);
        wrap    = (col_pre >= {1'b0, i_cfg.column_count});
        row_pre = wrap ? ({1'b0, r_row} + 3'd1) : {1'b0, r_row};
        put_row = (row_pre >= i_cfg.line_count) ? '0 : row_pre[ROW_W-1:0];
        put_col = wrap ? '0 : col_pre[COL_W-1:0];
        put_cmd  = ddram_cmd(put_col, put_row, i_cfg.column_count);
        move_cmd = ddram_cmd(i_target_column, i_target_row, i_cfg.column_count);

        n_col      = r_col;
        n_row      = r_row;
        n_wrapped  = r_wrapped;
        o_run.load = 1'b0;
        o_run.run  = '0;

        case (i_opcode)
            OP_PUT: begin
                o_run.load = i_accept;
                n_col      = put_col;
                n_row      = put_row;
                if (wrap) n_wrapped = !is_nl;
                if (skip) begin
                    o_run.run.slot[0] = nib_of(RS_CMD, put_cmd[7:4]);
                    o_run.run.slot[1] = nib_of(RS_CMD, put_cmd[3:0]);
                    o_run.run.last    = SLOT_W'(1);
                end else begin
                    o_run.run.slot[0] = nib_of(RS_DATA, i_char_code[7:4]);
                    o_run.run.slot[1] = nib_of(RS_DATA, i_char_code[3:0]);
                    o_run.run.slot[2] = nib_of(RS_CMD, put_cmd[7:4]);
                    o_run.run.slot[3] = nib_of(RS_CMD, put_cmd[3:0]);
                    o_run.run.last    = SLOT_W'(3);
                end
            end
            OP_MOVE: begin
                o_run.load        = i_accept;
                n_col             = i_target_column;
                n_row             = i_target_row;
                o_run.run.slot[0] = nib_of(RS_CMD, move_cmd[7:4]);
                o_run.run.slot[1] = nib_of(RS_CMD, move_cmd[3:0]);
                o_run.run.last    = SLOT_W'(1);
            end
            OP_CLEAR: begin
                o_run.load        = i_accept;
                n_col             = '0;
                n_row             = '0;
                o_run.run.slot[0] = nib_of(RS_CMD, CMD_CLEAR[7:4]);
                o_run.run.slot[1] = nib_of(RS_CMD, CMD_CLEAR[3:0]);
                o_run.run.slot[2] = nib_of(RS_CMD, CMD_HOME[7:4]);
                o_run.run.slot[3] = nib_of(RS_CMD, CMD_HOME[3:0]);
                o_run.run.last    = SLOT_W'(3);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_wrapped <= 1'b0;
        end else if (i_accept) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_wrapped <= n_wrapped;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lcdw_ser.sv -----
`default_nettype none

module lcdw_ser (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lcdw_pkg::t_run_load i_run,
    output logic                     o_can_load,
    lcdw_out_if.source               o_out
);
    import lcdw_pkg::*;

    logic              r_valid;
    logic [SLOT_W-1:0] r_idx;
    t_run              r_run;
    logic              take;
    logic              at_last;
    t_nibble           cur;

    always_comb begin
        cur        = r_run.slot[r_idx];
        at_last    = (r_idx == r_run.last);
        take       = r_valid && o_out.ready;
        o_can_load = !r_valid || (take && at_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_run.load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run.load) begin
            r_run <= i_run.run;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.register_select = cur.rs;
    assign o_out.bus_nibble      = cur.nib;
    assign o_out.last_of_run     = r_valid && at_last;

endmodule

`default_nettype wire

// ----- hw/rtl/char_lcd_cursor_writer_unit.sv -----
// channel   dir  handshake     word
// i_in      in   valid/ready   opcode, char_code, target_column, target_row
// o_out     out  valid/ready   register_select, bus_nibble, last_of_run
// cfg       in   i_cfg_we      i_cfg_index, i_cfg_data (no read-back)
//
// An operation yields 2 or 4 output words, one per cycle while o_out.ready is high, the first
// in the cycle after it is taken; opcode 3 is taken but yields no words and loads no run.
// The next operation is taken in the cycle its predecessor's last word leaves,
// since the run buffer holds only one run at a time.
// Reset (i_rst_n low, synchronous) zeroes cursor and wrap flag, loads 16 columns and 2 lines.
// o_out.ready low holds the current word; i_in.ready drops until the run drains.
`default_nettype none

module char_lcd_cursor_writer_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    lcdw_in_if.sink                        i_in,
    lcdw_out_if.source                     o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_index,
    input  wire logic [lcdw_pkg::COL_W-1:0] i_cfg_data
);
    import lcdw_pkg::*;

    t_cfg      w_cfg;
    t_run_load w_run;
    logic      w_can_load;
    logic      w_accept;

    assign i_in.ready = w_can_load;
    assign w_accept   = i_in.valid && w_can_load;

    lcdw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lcdw_step u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_opcode        (i_in.opcode),
        .i_char_code     (i_in.char_code),
        .i_target_column (i_in.target_column),
        .i_target_row    (i_in.target_row),
        .i_cfg           (w_cfg),
        .o_run           (w_run)
    );

    lcdw_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_run      (w_run),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

`ifndef ASSERT_OFF
    a_ready_only_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!o_out.valid || (o_out.ready && o_out.last_of_run)))
        else $error("input ready while a run is still pending");

    a_load_shows_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_run.load |=> o_out.valid)
        else $error("loaded run not presented");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_of_run && !w_run.load) |=> !o_out.valid)
        else $error("output still valid after last word taken");

    a_cfg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg.column_count <= COLS_MAX) && (w_cfg.line_count <= LINES_MAX))
        else $error("configuration out of range");
`endif

endmodule

`default_nettype wire
